>>> rtl/palette_osd_alpha_blend_macros.svh
// Assertion macros shared by the palette overlay blender.
// With SYNTH defined the macros expand to nothing.
`ifndef PALETTE_OSD_ALPHA_BLEND_MACROS_SVH
`define PALETTE_OSD_ALPHA_BLEND_MACROS_SVH

`ifndef SYNTH

// Implication checked at every rising edge outside reset.
`define POSD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("palette_osd_alpha_blend: implication check failed");

// Invariant checked at every rising edge outside reset.
`define POSD_ASSERT_ALW(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("palette_osd_alpha_blend: invariant check failed");

`else

`define POSD_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define POSD_ASSERT_ALW(lbl, clk, rst, expr)

`endif

`endif

>>> rtl/posd_pkg.sv
`default_nettype none

package posd_pkg;

  // Table sizes.
  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
  localparam logic [8:0] PAL_LIM = 9'(PALETTE_ENTRIES);
  localparam int INVERSE_ENTRIES = 65536;
  localparam int INV_AW          = $clog2(INVERSE_ENTRIES);

  // Field widths.
  localparam int FUNC_W     = 3;
  localparam int ADDR_W     = 16;
  localparam int WORD_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int RGB_W      = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // One lane carries a 9-bit signed operand: a zero-extended byte or a
  // sign-extended chroma byte.
  localparam int LANE_W    = 9;
  localparam int NUM_LANES = 3;

  // Result queue. The depth must be a power of two.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_BLEND    = 3'd0,
    FUNC_WR_ARGB  = 3'd1,
    FUNC_WR_AYUV  = 3'd2,
    FUNC_WR_MAP   = 3'd3,
    FUNC_WR_FRAME = 3'd4,
    FUNC_WR_INV   = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    MODE_ARGB   = 2'd0,
    MODE_LUMA   = 2'd1,
    MODE_CHROMA = 2'd2,
    MODE_INDEX  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLEND_MODE  = 1'b0,
    CFG_CHROMA_BIAS = 1'b1
  } cfg_idx_t;

  // Alpha class of the overlay entry.
  typedef enum logic [1:0] {
    KIND_KEEP = 2'd0,
    KIND_MIX  = 2'd1,
    KIND_FULL = 2'd2
  } kind_t;

  typedef struct packed {
    logic [WORD_W-1:0] pixel;
    logic [BYTE_W-1:0] v;
  } rsp_t;

  typedef struct packed {
    logic             empty;
    logic             full;
    logic [LVL_W-1:0] level;
  } fifo_stat_t;

endpackage

`default_nettype wire

>>> rtl/posd_lane.sv
`default_nettype none

// One color channel of the over operator: (s*a + d*(255-a)) / 255 with the
// quotient truncated toward zero. Four register stages.
module posd_lane
  import posd_pkg::*;
(
  input  logic                     clk,
  input  logic signed [LANE_W-1:0] s,
  input  logic signed [LANE_W-1:0] d,
  input  logic        [BYTE_W-1:0] a,
  output logic        [BYTE_W-1:0] m
);

  logic signed [LANE_W-1:0] s_r;
  logic signed [LANE_W-1:0] d_r;
  logic        [BYTE_W-1:0] a_r;

  logic signed [LANE_W:0]   diff;
  logic signed [17:0]       d_ext;
  logic signed [17:0]       d255;
  logic signed [17:0]       prod;
  logic signed [17:0]       sum_c;
  logic signed [17:0]       sum_r;

  logic                     neg_c;
  logic signed [17:0]       mag_full;
  logic        [15:0]       mag_c;
  logic        [15:0]       approx;
  logic        [15:0]       mag_r;
  logic        [7:0]        q0_r;
  logic                     neg_r;

  logic        [15:0]       q0x255;
  logic        [15:0]       rem;
  logic        [8:0]        q;
  logic        [8:0]        mres;

  always_ff @(posedge clk) begin
    s_r <= s;
    d_r <= d;
    a_r <= a;
  end

  // The sum is rewritten as d*255 + (s-d)*a so that one multiplier serves.
  always_comb begin
    diff  = {s_r[LANE_W-1], s_r} - {d_r[LANE_W-1], d_r};
    d_ext = {{(18 - LANE_W){d_r[LANE_W-1]}}, d_r};
    d255  = (d_ext <<< 8) - d_ext;
    prod  = diff * $signed({1'b0, a_r});
    sum_c = prod + d255;
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_c;
  end

  // Quotient estimate (x + x/256) / 256 is low by at most one.
  always_comb begin
    neg_c    = sum_r[17];
    mag_full = neg_c ? (18'sd0 - sum_r) : sum_r;
    mag_c    = mag_full[15:0];
    approx   = mag_c + {8'd0, mag_c[15:8]};
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_c;
    q0_r  <= approx[15:8];
    neg_r <= neg_c;
  end

  always_comb begin
    q0x255 = {q0_r, 8'd0} - {8'd0, q0_r};
    rem    = mag_r - q0x255;
    q      = {1'b0, q0_r} + 9'(rem >= 16'd255);
    mres   = neg_r ? (9'd0 - q) : q;
  end

  always_ff @(posedge clk) begin
    m <= mres[BYTE_W-1:0];
  end

endmodule

`default_nettype wire

>>> rtl/posd_fifo.sv
`default_nettype none

// Small result queue that parts the blend pipeline from the result channel.
module posd_fifo
  import posd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  rsp_t       push_data,
  input  logic       pop,
  output rsp_t       head,
  output fifo_stat_t stat
);

  rsp_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [LVL_W-1:0]   level;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      level <= level + LVL_W'(push) - LVL_W'(pop);
    end
  end

  assign head       = mem[rd_ptr];
  assign stat.empty = (level == '0);
  assign stat.full  = (level == LVL_W'(FIFO_DEPTH));
  assign stat.level = level;

endmodule

`default_nettype wire

>>> rtl/palette_osd_alpha_blend.sv
// A blend request passes stage one, stages two to five and stage six before its result is queued.
// Throughput: one request per cycle while req_stall is low; table writes flow through the same 6 stages.
// req_stall rises in reset and when 8 results are queued or in flight (credit counter).
// Reset clears the pipeline, the queue, the config registers and the overlay tables'
// valid bits; frame palette and inverse table are not cleared, no clearing pass.
`default_nettype none

`include "palette_osd_alpha_blend_macros.svh"

module palette_osd_alpha_blend
  import posd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,

  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [FUNC_W-1:0]     func,
  input  logic [ADDR_W-1:0]     table_addr,
  input  logic [WORD_W-1:0]     table_data,
  input  logic [BYTE_W-1:0]     osd_code,
  input  logic [WORD_W-1:0]     back_pixel,
  input  logic [BYTE_W-1:0]     back_v,

  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic [WORD_W-1:0]     out_pixel,
  output logic [BYTE_W-1:0]     out_v,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Stage one holds the request fields next to the registered table reads.
  typedef struct packed {
    logic              vld;
    logic              blend;
    logic              wr_inv;
    logic [INV_AW-1:0] inv_addr;
    logic [BYTE_W-1:0] inv_data;
    logic [WORD_W-1:0] back;
    logic [BYTE_W-1:0] bv;
  } s1_t;

  // Stages two to five carry the control of a request alongside the lanes.
  typedef struct packed {
    logic              vld;
    logic              blend;
    logic              wr_inv;
    logic [INV_AW-1:0] inv_addr;
    logic [BYTE_W-1:0] inv_data;
    kind_t             kind;
    logic [WORD_W-1:0] e;
    logic [WORD_W-1:0] back;
    logic [BYTE_W-1:0] bv;
    logic [BYTE_W-1:0] map;
  } ctl_t;

  // Stage six holds the assembled result, less the inverse table lookup.
  typedef struct packed {
    logic              vld;
    logic              blend;
    logic              use_inv;
    logic [WORD_W-1:0] px;
    logic [BYTE_W-1:0] v;
  } s6_t;

  // Configuration registers.
  mode_t             blend_mode;
  logic [BYTE_W-1:0] chroma_bias;

  // Overlay tables reset to zero (transparent) through per-entry valid bits.
  logic [WORD_W-1:0]          argb_mem [PALETTE_ENTRIES];
  logic [WORD_W-1:0]          ayuv_mem [PALETTE_ENTRIES];
  logic [BYTE_W-1:0]          map_mem  [PALETTE_ENTRIES];
  logic [RGB_W-1:0]           fp_mem   [PALETTE_ENTRIES];
  logic [BYTE_W-1:0]          inv_mem  [INVERSE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] argb_vld;
  logic [PALETTE_ENTRIES-1:0] ayuv_vld;
  logic [PALETTE_ENTRIES-1:0] map_vld;

  logic [WORD_W-1:0] argb_q;
  logic [WORD_W-1:0] ayuv_q;
  logic [BYTE_W-1:0] map_q;
  logic [RGB_W-1:0]  fp_q;
  logic              argb_ok_q;
  logic              ayuv_ok_q;
  logic              map_ok_q;
  logic              fp_ok_q;
  logic [BYTE_W-1:0] inv_q;

  logic              req_acc;
  logic              acc_blend;
  logic              wr_ok;
  logic [PAL_AW-1:0] wr_idx;
  logic [PAL_AW-1:0] code_idx;
  logic              code_ok;
  logic [PAL_AW-1:0] back_idx;
  logic              back_ok;

  s1_t               p1;
  ctl_t              c1;
  ctl_t              pipe [2:5];
  s6_t               c6;
  s6_t               p6;

  logic [WORD_W-1:0] e_argb;
  logic [WORD_W-1:0] e_ayuv;
  logic [WORD_W-1:0] e_sel;
  logic [RGB_W-1:0]  fp_sel;
  logic [BYTE_W-1:0] alpha;
  logic [BYTE_W-1:0] b8;
  logic [BYTE_W-1:0] cu_s;
  logic [BYTE_W-1:0] cu_d;
  logic [BYTE_W-1:0] cv_s;
  logic [BYTE_W-1:0] cv_d;

  logic signed [LANE_W-1:0] lane_s [NUM_LANES];
  logic signed [LANE_W-1:0] lane_d [NUM_LANES];
  logic        [BYTE_W-1:0] lane_m [NUM_LANES];

  logic [INV_AW-1:0] key5;

  logic              push;
  rsp_t              push_data;
  rsp_t              head;
  fifo_stat_t        fifo_stat;
  logic              pop;

  logic [LVL_W-1:0]  credit;
  logic [LVL_W-1:0]  credit_next;
  logic [LVL_W-1:0]  blend_owed;

  // ---------------------------------------------------------------------------
  // Request handshake and result credits. Every blend request holds a credit
  // from acceptance until its result leaves, so the queue can never overflow
  // and the pipeline itself never has to stop.
  // ---------------------------------------------------------------------------
  assign req_stall = rst | (credit == LVL_W'(FIFO_DEPTH));
  assign req_acc   = req_valid & ~req_stall;
  assign acc_blend = req_acc & (func == FUNC_BLEND);
  assign pop       = rsp_valid & ~rsp_stall;

  always_comb begin
    credit_next = credit + LVL_W'(acc_blend) - LVL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      credit <= credit_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration. The user must write it only while the block is idle; the block itself does not enforce this.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode  <= MODE_ARGB;
      chroma_bias <= 8'h80;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BLEND_MODE:  blend_mode  <= mode_t'(cfg_data[1:0]);
        CFG_CHROMA_BIAS: chroma_bias <= cfg_data[BYTE_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage one: palette tables. Writes and reads of the 256-entry tables both
  // happen at the acceptance edge, so a blend sees every earlier write.
  // ---------------------------------------------------------------------------
  assign wr_idx   = table_addr[PAL_AW-1:0];
  assign wr_ok    = ({1'b0, table_addr[BYTE_W-1:0]} < PAL_LIM);
  assign code_idx = osd_code[PAL_AW-1:0];
  assign code_ok  = ({1'b0, osd_code} < PAL_LIM);
  assign back_idx = back_pixel[PAL_AW-1:0];
  assign back_ok  = ({1'b0, back_pixel[BYTE_W-1:0]} < PAL_LIM);

  always_ff @(posedge clk) begin
    if (req_acc && func == FUNC_WR_ARGB && wr_ok) begin
      argb_mem[wr_idx] <= table_data;
    end
    argb_q <= argb_mem[code_idx];
  end

  always_ff @(posedge clk) begin
    if (req_acc && func == FUNC_WR_AYUV && wr_ok) begin
      ayuv_mem[wr_idx] <= table_data;
    end
    ayuv_q <= ayuv_mem[code_idx];
  end

  always_ff @(posedge clk) begin
    if (req_acc && func == FUNC_WR_MAP && wr_ok) begin
      map_mem[wr_idx] <= table_data[BYTE_W-1:0];
    end
    map_q <= map_mem[code_idx];
  end

  always_ff @(posedge clk) begin
    if (req_acc && func == FUNC_WR_FRAME && wr_ok) begin
      fp_mem[wr_idx] <= table_data[RGB_W-1:0];
    end
    fp_q <= fp_mem[back_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      argb_vld <= '0;
      ayuv_vld <= '0;
      map_vld  <= '0;
    end else if (req_acc && wr_ok) begin
      if (func == FUNC_WR_ARGB) begin
        argb_vld[wr_idx] <= 1'b1;
      end
      if (func == FUNC_WR_AYUV) begin
        ayuv_vld[wr_idx] <= 1'b1;
      end
      if (func == FUNC_WR_MAP) begin
        map_vld[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    argb_ok_q   <= argb_vld[code_idx] & code_ok;
    ayuv_ok_q   <= ayuv_vld[code_idx] & code_ok;
    map_ok_q    <= map_vld[code_idx] & code_ok;
    fp_ok_q     <= back_ok;
    p1.blend    <= (func == FUNC_BLEND);
    p1.wr_inv   <= (func == FUNC_WR_INV);
    p1.inv_addr <= table_addr[INV_AW-1:0];
    p1.inv_data <= table_data[BYTE_W-1:0];
    p1.back     <= back_pixel;
    p1.bv       <= back_v;
    if (rst) begin
      p1.vld <= 1'b0;
    end else begin
      p1.vld <= req_acc;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage one logic: pick the overlay entry for the mode, classify its alpha
  // and set up the operands of the three channel lanes. Chroma is moved to
  // two's complement form by the bias byte and sign-extended.
  // ---------------------------------------------------------------------------
  always_comb begin
    e_argb = argb_ok_q ? argb_q : '0;
    e_ayuv = ayuv_ok_q ? ayuv_q : '0;
    fp_sel = fp_ok_q ? fp_q : '0;
    e_sel  = (blend_mode == MODE_LUMA || blend_mode == MODE_CHROMA) ? e_ayuv : e_argb;
    alpha  = e_sel[31:24];
    b8     = p1.back[BYTE_W-1:0];
    cu_s   = e_sel[15:8] ^ chroma_bias;
    cu_d   = b8 ^ chroma_bias;
    cv_s   = e_sel[7:0] ^ chroma_bias;
    cv_d   = p1.bv ^ chroma_bias;

    for (int i = 0; i < NUM_LANES; i++) begin
      lane_s[i] = '0;
      lane_d[i] = '0;
    end

    unique case (blend_mode)
      MODE_ARGB: begin
        lane_s[0] = {1'b0, e_sel[23:16]};
        lane_d[0] = {1'b0, p1.back[23:16]};
        lane_s[1] = {1'b0, e_sel[15:8]};
        lane_d[1] = {1'b0, p1.back[15:8]};
        lane_s[2] = {1'b0, e_sel[7:0]};
        lane_d[2] = {1'b0, p1.back[7:0]};
      end
      MODE_LUMA: begin
        lane_s[0] = {1'b0, e_sel[23:16]};
        lane_d[0] = {1'b0, b8};
      end
      MODE_CHROMA: begin
        lane_s[0] = {cu_s[7], cu_s};
        lane_d[0] = {cu_d[7], cu_d};
        lane_s[1] = {cv_s[7], cv_s};
        lane_d[1] = {cv_d[7], cv_d};
      end
      MODE_INDEX: begin
        lane_s[0] = {1'b0, e_sel[23:16]};
        lane_d[0] = {1'b0, fp_sel[23:16]};
        lane_s[1] = {1'b0, e_sel[15:8]};
        lane_d[1] = {1'b0, fp_sel[15:8]};
        lane_s[2] = {1'b0, e_sel[7:0]};
        lane_d[2] = {1'b0, fp_sel[7:0]};
      end
    endcase

    c1.vld      = p1.vld;
    c1.blend    = p1.blend;
    c1.wr_inv   = p1.wr_inv;
    c1.inv_addr = p1.inv_addr;
    c1.inv_data = p1.inv_data;
    c1.e        = e_sel;
    c1.back     = p1.back;
    c1.bv       = p1.bv;
    c1.map      = map_ok_q ? map_q : '0;
    if (alpha == 8'hff) begin
      c1.kind = KIND_FULL;
    end else if (alpha == 8'h00) begin
      c1.kind = KIND_KEEP;
    end else begin
      c1.kind = KIND_MIX;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages two to five: the lanes multiply, add and divide by 255 while the
  // control of each request moves alongside them.
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    posd_lane u_lane (
      .clk (clk),
      .s   (lane_s[g]),
      .d   (lane_d[g]),
      .a   (c1.e[31:24]),
      .m   (lane_m[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 2; i <= 5; i++) begin
        pipe[i] <= '0;
      end
    end else begin
      pipe[2] <= c1;
      for (int i = 3; i <= 5; i++) begin
        pipe[i] <= pipe[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage five logic: assemble the result word for the mode. In indexed mode
  // a partial blend is folded to RGB565 and looked up in the inverse table,
  // which is read and written at the next edge, in request order.
  // ---------------------------------------------------------------------------
  always_comb begin
    key5       = {lane_m[0][7:3], lane_m[1][7:2], lane_m[2][7:3]};
    c6.vld     = pipe[5].vld;
    c6.blend   = pipe[5].blend;
    c6.use_inv = 1'b0;
    c6.px      = '0;
    c6.v       = '0;

    unique case (blend_mode)
      MODE_ARGB: begin
        case (pipe[5].kind)
          KIND_FULL: c6.px = pipe[5].e;
          KIND_KEEP: c6.px = pipe[5].back;
          default:   c6.px = {8'h00, lane_m[0], lane_m[1], lane_m[2]};
        endcase
      end
      MODE_LUMA: begin
        case (pipe[5].kind)
          KIND_FULL: c6.px = {24'd0, pipe[5].e[23:16]};
          KIND_KEEP: c6.px = {24'd0, pipe[5].back[7:0]};
          default:   c6.px = {24'd0, lane_m[0]};
        endcase
      end
      MODE_CHROMA: begin
        case (pipe[5].kind)
          KIND_FULL: begin
            c6.px = {24'd0, pipe[5].e[15:8]};
            c6.v  = pipe[5].e[7:0];
          end
          KIND_KEEP: begin
            c6.px = {24'd0, pipe[5].back[7:0]};
            c6.v  = pipe[5].bv;
          end
          default: begin
            c6.px = {24'd0, lane_m[0] ^ chroma_bias};
            c6.v  = lane_m[1] ^ chroma_bias;
          end
        endcase
      end
      MODE_INDEX: begin
        case (pipe[5].kind)
          KIND_FULL: c6.px = {24'd0, pipe[5].map};
          KIND_KEEP: c6.px = {24'd0, pipe[5].back[7:0]};
          default:   c6.use_inv = 1'b1;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pipe[5].vld && pipe[5].wr_inv) begin
      inv_mem[pipe[5].inv_addr] <= pipe[5].inv_data;
    end
    inv_q <= inv_mem[key5];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p6 <= '0;
    end else begin
      p6 <= c6;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage six: final selection and hand-off to the result queue.
  // ---------------------------------------------------------------------------
  assign push            = p6.vld & p6.blend;
  assign push_data.pixel = p6.use_inv ? {24'd0, inv_q} : p6.px;
  assign push_data.v     = p6.v;

  posd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (fifo_stat)
  );

  assign rsp_valid = ~fifo_stat.empty;
  assign out_pixel = head.pixel;
  assign out_v     = head.v;

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  // Results queued plus blend requests still in the stages.
  assign blend_owed = fifo_stat.level + LVL_W'($countones({
      p1.vld & p1.blend, pipe[2].vld & pipe[2].blend, pipe[3].vld & pipe[3].blend,
      pipe[4].vld & pipe[4].blend, pipe[5].vld & pipe[5].blend, p6.vld & p6.blend}));

  // Every result entering the queue belongs to a blend request accepted earlier and
  // carried through stage one, stages two to five and stage six.
  `POSD_ASSERT_IMP(a_push_origin, clk, rst, push, $past(acc_blend, 6))
  // The credit scheme keeps the queue from overflowing.
  `POSD_ASSERT_IMP(a_push_room, clk, rst, push, !fifo_stat.full)
  // Credits equal queued results plus blend requests still in the stages.
  `POSD_ASSERT_ALW(a_credit_sum, clk, rst, credit == blend_owed)
  // A waiting result always holds a credit.
  `POSD_ASSERT_IMP(a_valid_credit, clk, rst, rsp_valid, credit != '0)

endmodule

`default_nettype wire

>>> tb/posd_blend_check_pkg.sv
`timescale 1ns / 1ps

package posd_blend_check_pkg;

  import posd_pkg::*;

  // Mirrors the overlay tables and registers and queues the pixels that the blender owes.
  class overlay_blend_predictor;

    logic [WORD_W-1:0] argb_pal [PALETTE_ENTRIES];
    logic [WORD_W-1:0] ayuv_pal [PALETTE_ENTRIES];
    logic [BYTE_W-1:0] code_to_index [PALETTE_ENTRIES];
    logic [RGB_W-1:0]  frame_rgb [PALETTE_ENTRIES];
    logic [BYTE_W-1:0] inv565 [INVERSE_ENTRIES];
    bit                frame_known [PALETTE_ENTRIES];
    bit                inv_known [INVERSE_ENTRIES];
    mode_t             mode;
    logic [BYTE_W-1:0] bias;
    rsp_t              pending_px [$];
    int                errors;

    function new();
      foreach (argb_pal[i]) begin
        argb_pal[i] = '0;
        ayuv_pal[i] = '0;
        code_to_index[i] = '0;
        frame_rgb[i] = '0;
        frame_known[i] = 1'b0;
      end
      foreach (inv565[i]) begin
        inv565[i] = '0;
        inv_known[i] = 1'b0;
      end
      mode = MODE_ARGB;
      bias = 8'd128;
      errors = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function int pending();
      return pending_px.size();
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_BLEND_MODE: mode = mode_t'(data[1:0]);
        CFG_CHROMA_BIAS: bias = data;
        default: ;
      endcase
    endfunction

    function logic [7:0] mix_byte(logic [7:0] s, logic [7:0] d, logic [7:0] a);
      int total;
      total = int'(s) * int'(a) + int'(d) * (255 - int'(a));
      return 8'(total / 255);
    endfunction

    // Chroma is blended as a signed byte; SV division truncates toward zero.
    function logic [7:0] mix_chroma(logic [7:0] s, logic [7:0] d, logic [7:0] a);
      int su;
      int du;
      int m;
      su = int'($signed(s ^ bias));
      du = int'($signed(d ^ bias));
      m = (su * int'(a) + du * (255 - int'(a))) / 255;
      return 8'(m) ^ bias;
    endfunction

    // RGB565 key of the overlay entry blended over a frame palette color.
    function logic [15:0] rgb565_key(logic [7:0] code, logic [7:0] b8);
      logic [WORD_W-1:0] e;
      logic [RGB_W-1:0]  rp;
      logic [7:0]        r;
      logic [7:0]        g;
      logic [7:0]        b;
      e = argb_pal[code];
      rp = frame_rgb[b8];
      r = mix_byte(e[23:16], rp[23:16], e[31:24]);
      g = mix_byte(e[15:8], rp[15:8], e[31:24]);
      b = mix_byte(e[7:0], rp[7:0], e[31:24]);
      return {r[7:3], g[7:2], b[7:3]};
    endfunction

    function rsp_t blend_pixel(logic [7:0] code, logic [WORD_W-1:0] back, logic [7:0] bv);
      rsp_t              res;
      logic [WORD_W-1:0] e;
      logic [7:0]        a;
      logic [7:0]        b8;
      res = '0;
      b8 = back[7:0];
      e = (mode == MODE_LUMA || mode == MODE_CHROMA) ? ayuv_pal[code] : argb_pal[code];
      a = e[31:24];
      case (mode)
        MODE_ARGB: begin
          if (a == 8'hFF) res.pixel = e;
          else if (a == 8'h00) res.pixel = back;
          else res.pixel = {8'h00, mix_byte(e[23:16], back[23:16], a),
                            mix_byte(e[15:8], back[15:8], a), mix_byte(e[7:0], back[7:0], a)};
        end
        MODE_LUMA: begin
          if (a == 8'hFF) res.pixel = {24'h0, e[23:16]};
          else if (a == 8'h00) res.pixel = {24'h0, b8};
          else res.pixel = {24'h0, mix_byte(e[23:16], b8, a)};
        end
        MODE_CHROMA: begin
          if (a == 8'hFF) begin
            res.pixel = {24'h0, e[15:8]};
            res.v = e[7:0];
          end else if (a == 8'h00) begin
            res.pixel = {24'h0, b8};
            res.v = bv;
          end else begin
            res.pixel = {24'h0, mix_chroma(e[15:8], b8, a)};
            res.v = mix_chroma(e[7:0], bv, a);
          end
        end
        default: begin
          if (a == 8'hFF) res.pixel = {24'h0, code_to_index[code]};
          else if (a == 8'h00) res.pixel = {24'h0, b8};
          else res.pixel = {24'h0, inv565[rgb565_key(code, b8)]};
        end
      endcase
      return res;
    endfunction

    function void note_request(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] addr,
                               logic [WORD_W-1:0] data, logic [7:0] code,
                               logic [WORD_W-1:0] back, logic [7:0] bv);
      case (f)
        FUNC_BLEND: pending_px.push_back(blend_pixel(code, back, bv));
        FUNC_WR_ARGB: argb_pal[addr[7:0]] = data;
        FUNC_WR_AYUV: ayuv_pal[addr[7:0]] = data;
        FUNC_WR_MAP: code_to_index[addr[7:0]] = data[7:0];
        FUNC_WR_FRAME: begin
          frame_rgb[addr[7:0]] = data[RGB_W-1:0];
          frame_known[addr[7:0]] = 1'b1;
        end
        FUNC_WR_INV: begin
          inv565[addr] = data[7:0];
          inv_known[addr] = 1'b1;
        end
        default: ;
      endcase
    endfunction

    task check_result(logic [WORD_W-1:0] pixel, logic [7:0] v);
      rsp_t want;
      if (pending_px.size() == 0) begin
        report($sformatf("result %h/%h arrived with nothing outstanding", pixel, v));
        return;
      end
      want = pending_px.pop_front();
      if (pixel !== want.pixel)
        report($sformatf("out_pixel got %h, want %h", pixel, want.pixel));
      if (v !== want.v)
        report($sformatf("out_v got %h, want %h", v, want.v));
    endtask

  endclass

endpackage

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import posd_pkg::*;
  import posd_blend_check_pkg::*;

  // Idle time allowed after the last result when settling before a register write and
  // at the very end.
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 10;
  localparam int RANDOM_PER_PHASE = 50;
  // Function codes that the block must ignore without producing a result.
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  logic [FUNC_W-1:0]     func = FUNC_BLEND;
  logic [ADDR_W-1:0]     table_addr = '0;
  logic [WORD_W-1:0]     table_data = '0;
  logic [BYTE_W-1:0]     osd_code = '0;
  logic [WORD_W-1:0]     back_pixel = '0;
  logic [BYTE_W-1:0]     back_v = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  logic [WORD_W-1:0]     out_pixel;
  logic [BYTE_W-1:0]     out_v;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_BLEND_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // When set, neither side inserts idle cycles, so the pipeline runs at full rate.
  bit steady_run = 1'b0;
  int unsigned cycle_count = 0;

  overlay_blend_predictor pred = new();

  mode_t phase_mode [PHASES] = '{MODE_ARGB, MODE_LUMA, MODE_CHROMA, MODE_INDEX, MODE_CHROMA,
                                 MODE_INDEX, MODE_LUMA, MODE_ARGB, MODE_CHROMA, MODE_INDEX};

  palette_osd_alpha_blend i_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .func       (func),
    .table_addr (table_addr),
    .table_data (table_data),
    .osd_code   (osd_code),
    .back_pixel (back_pixel),
    .back_v     (back_v),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .out_pixel  (out_pixel),
    .out_v      (out_v),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // The result side stalls at random, except during the steady stretch.
  always @(negedge clk) begin
    rsp_stall <= !steady_run && ($urandom_range(99) < 26);
  end

  // Every result taken at a rising edge is compared with the oldest predicted pixel.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) pred.check_result(out_pixel, out_v);
  end

  // A hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Presents one request, holds it steady until the block takes it and then records it
  // in the predictor. Entered and left at a falling edge.
  task automatic send_req(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] addr,
                          input logic [WORD_W-1:0] data, input logic [7:0] code,
                          input logic [WORD_W-1:0] back, input logic [7:0] bv);
    while (!steady_run && $urandom_range(99) < 26) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    func <= f;
    table_addr <= addr;
    table_data <= data;
    osd_code <= code;
    back_pixel <= back;
    back_v <= bv;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pred.note_request(f, addr, data, code, back, bv);
    @(negedge clk);
  endtask

  // A partial blend in indexed mode reads the frame palette and the inverse table.
  // Those are never cleared, so any entry the blend is about to read is written first.
  task automatic send_blend(input logic [7:0] code, input logic [WORD_W-1:0] back,
                            input logic [7:0] bv);
    logic [7:0]  alpha;
    logic [15:0] key;
    alpha = pred.argb_pal[code][31:24];
    if (pred.mode == MODE_INDEX && alpha != 8'h00 && alpha != 8'hFF) begin
      if (!pred.frame_known[back[7:0]])
        send_req(FUNC_WR_FRAME, {8'($urandom_range(255)), back[7:0]}, $urandom(),
                 code, back, bv);
      key = pred.rgb565_key(code, back[7:0]);
      if (!pred.inv_known[key])
        send_req(FUNC_WR_INV, key, $urandom(), code, back, bv);
    end
    send_req(FUNC_BLEND, 16'($urandom()), $urandom(), code, back, bv);
  endtask

  // Stops issuing requests and waits until every predicted result has come back and
  // the pipeline has had time to flush the table writes behind it.
  task automatic drain_results();
    req_valid <= 1'b0;
    @(negedge clk);
    while (pred.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Most codes land in a small hot set so that blends usually hit written entries.
  function automatic logic [7:0] pick_code();
    return ($urandom_range(99) < 70) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
  endfunction

  // Palette word with the interesting alphas (keep, replace, the edges of blending)
  // well represented.
  function automatic logic [WORD_W-1:0] pick_entry();
    int unsigned r;
    logic [7:0]  alpha;
    r = $urandom_range(99);
    if (r < 20) alpha = 8'hFF;
    else if (r < 40) alpha = 8'h00;
    else if (r < 48) alpha = 8'h01;
    else if (r < 56) alpha = 8'hFE;
    else alpha = 8'($urandom_range(255));
    return {alpha, 24'($urandom())};
  endfunction

  function automatic logic [WORD_W-1:0] pick_back();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return $urandom();
  endfunction

  initial begin
    logic [7:0]  bias;
    int unsigned r;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int p = 0; p < PHASES; p++) begin
      // Registers change only while nothing is in flight.
      drain_results();
      case (p)
        2: bias = 8'd128;
        4: bias = 8'd0;
        8: bias = 8'd255;
        default: bias = 8'($urandom_range(255));
      endcase
      cfg_we <= 1'b1;
      cfg_index <= CFG_BLEND_MODE;
      cfg_data <= {6'($urandom_range(63)), phase_mode[p]};
      pred.write_reg(CFG_BLEND_MODE, {6'h0, phase_mode[p]});
      @(negedge clk);
      cfg_index <= CFG_CHROMA_BIAS;
      cfg_data <= bias;
      pred.write_reg(CFG_CHROMA_BIAS, bias);
      @(negedge clk);
      cfg_we <= 1'b0;
      steady_run = (p == 5);

      // Directed part: palette entries that replace, keep and blend at the alpha
      // extremes, then blends against all-zero and all-one backgrounds in each mode.
      if (p == 0) begin
        send_req(FUNC_WR_ARGB, 16'h0000, 32'hFF12_3456, 8'h00, '0, 8'h00);
        send_req(FUNC_WR_ARGB, 16'hFF01, 32'h00AB_CDEF, 8'hFF, '1, 8'hFF);
        send_req(FUNC_WR_ARGB, 16'h0002, 32'h01FF_FFFF, 8'h00, '0, 8'h00);
        send_req(FUNC_WR_ARGB, 16'h8003, 32'hFE80_FF01, 8'h00, '0, 8'h00);
        send_req(FUNC_WR_AYUV, 16'h0000, 32'hFFFF_00FF, 8'h00, '0, 8'h00);
        send_req(FUNC_WR_AYUV, 16'h0001, 32'h0012_3456, 8'h00, '0, 8'h00);
        send_req(FUNC_WR_AYUV, 16'h0002, 32'h0180_FF7F, 8'h00, '0, 8'h00);
        send_req(FUNC_WR_AYUV, 16'h7F03, 32'hFE00_7F80, 8'h00, '0, 8'h00);
        send_req(FUNC_WR_MAP, 16'h0000, 32'h0000_00A5, 8'h00, '0, 8'h00);
      end
      if (p < 4) begin
        for (int k = 0; k < 4; k++)
          send_blend(8'(k), k[0] ? '1 : '0, k[0] ? 8'hFF : 8'h00);
      end
      if (p == 0) begin
        // A never-written overlay entry is transparent, and the two spare function
        // codes must pass through without a result.
        send_blend(8'd200, 32'hA5C3_0F96, 8'h3C);
        send_req(FUNC_SPARE_LO, '1, '1, 8'hFF, '1, 8'hFF);
        send_req(FUNC_SPARE_HI, '0, '0, 8'h00, '0, 8'h00);
      end

      // Random part: mostly blends and palette updates against the hot set of codes.
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        r = $urandom_range(99);
        if (r < 50)
          send_blend(pick_code(), pick_back(), 8'($urandom_range(255)));
        else if (r < 62)
          send_req(FUNC_WR_ARGB, {8'($urandom_range(255)), pick_code()}, pick_entry(),
                   8'($urandom_range(255)), $urandom(), 8'($urandom_range(255)));
        else if (r < 74)
          send_req(FUNC_WR_AYUV, {8'($urandom_range(255)), pick_code()}, pick_entry(),
                   8'($urandom_range(255)), $urandom(), 8'($urandom_range(255)));
        else if (r < 82)
          send_req(FUNC_WR_MAP, {8'($urandom_range(255)), pick_code()}, $urandom(),
                   8'($urandom_range(255)), $urandom(), 8'($urandom_range(255)));
        else if (r < 90)
          send_req(FUNC_WR_FRAME, 16'($urandom()), $urandom(),
                   8'($urandom_range(255)), $urandom(), 8'($urandom_range(255)));
        else if (r < 97)
          send_req(FUNC_WR_INV, 16'($urandom()), $urandom(),
                   8'($urandom_range(255)), $urandom(), 8'($urandom_range(255)));
        else
          send_req(r[0] ? FUNC_SPARE_HI : FUNC_SPARE_LO, 16'($urandom()), $urandom(),
                   8'($urandom_range(255)), $urandom(), 8'($urandom_range(255)));
      end
    end

    drain_results();
    if (pred.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/posd_pkg.sv
rtl/posd_lane.sv
rtl/posd_fifo.sv
rtl/palette_osd_alpha_blend.sv
tb/posd_blend_check_pkg.sv
tb/tb_top.sv
